@@ rtl/mpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm_pkg
// Request and status codes and the word types of the multi-pattern matcher.
// ----------------------------------------------------------------------------
package mpm_pkg;

  typedef enum logic [2:0] {
    REQ_ADD     = 3'd0,
    REQ_FINAL   = 3'd1,
    REQ_SCAN    = 3'd2,
    REQ_RESTART = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_type_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_READY = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] symbol;
    logic       pattern_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] node_id;
    logic       hit;
    logic [1:0] status;
  } out_word_t;

endpackage

@@ rtl/mpm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mpm_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/multi_pattern_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_matcher
// Aho-Corasick automaton: trie build, breadth-first failure links, scanning.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; its single result
// word appears on out_word for one cycle with out_valid. Restart, clear, unused
// requests and a scan before finalize answer in the next cycle; an add goes
// through S_ADD_CHK; a scan through S_WK_CHK, S_WK_FL and S_WK_CHK again per
// failure link followed, then S_SC_OUT, each child lookup using the single read
// port of the child table. Finalize walks every node breadth first: S_BF_RD and
// S_BF_V per (node, symbol) pair, S_BF_E per child found (after a failure walk
// for a non-root child), S_BF_U and S_BF_FU per node taken from the queue. After
// reset and after a clear the child table is swept to zero with busy high.
// ----------------------------------------------------------------------------
module multi_pattern_matcher #(
  parameter int MAX_NODES   = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mpm_pkg::in_word_t in_word,
  output logic              out_valid,
  output mpm_pkg::out_word_t out_word
);
  import mpm_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int SB = SYMBOL_BITS;
  localparam int CW = NW + SB;
  localparam logic [NW:0] MAXN = (NW+1)'(MAX_NODES);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_CLR     = 11'b00000000010,
    S_ADD_CHK = 11'b00000000100,
    S_WK_CHK  = 11'b00000001000,
    S_WK_FL   = 11'b00000010000,
    S_SC_OUT  = 11'b00000100000,
    S_BF_RD   = 11'b00001000000,
    S_BF_V    = 11'b00010000000,
    S_BF_E    = 11'b00100000000,
    S_BF_U    = 11'b01000000000,
    S_BF_FU   = 11'b10000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [NW-1:0] cursor_r, cursor_nxt, scan_r, scan_nxt;
  logic [NW:0]   count_r, count_nxt, guard_r, guard_nxt;
  logic [NW:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic          ready_r, ready_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;
  logic [SB-1:0] sym_r, sym_nxt;
  logic          last_r, last_nxt, root_r, root_nxt, wscan_r, wscan_nxt;
  logic [NW-1:0] u_r, u_nxt, fu_r, fu_nxt, v_r, v_nxt, w_r, w_nxt, f_r, f_nxt;

  logic          ch_we, fl_we, en_we, q_we;
  logic [CW-1:0] ch_waddr, ch_raddr;
  logic [NW-1:0] ch_wdata, ch_rdata, fl_waddr, fl_wdata, fl_raddr, fl_rdata;
  logic [NW-1:0] en_waddr, en_raddr, q_rdata;
  logic          en_wdata, en_rdata;
  logic [SB-1:0] sym_in;
  logic [SB+7:0] sym_ext;

  function automatic logic [7:0] node8(input logic [NW-1:0] n);
    logic [NW+7:0] t;
    t = {8'b0, n};
    return t[7:0];
  endfunction

  assign sym_ext   = {{SB{1'b0}}, in_word.symbol};
  assign sym_in    = sym_ext[SB-1:0];
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  mpm_ram #(.AW(CW), .DW(NW)) u_child (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata_r(ch_rdata)
  );
  mpm_ram #(.AW(NW), .DW(NW)) u_fail (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata_r(fl_rdata)
  );
  mpm_ram #(.AW(NW), .DW(1)) u_ends (
    .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
    .raddr(en_raddr), .rdata_r(en_rdata)
  );
  mpm_ram #(.AW(NW), .DW(NW)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail_r[NW-1:0]), .wdata(v_nxt),
    .raddr(head_r[NW-1:0]), .rdata_r(q_rdata)
  );

  always_comb begin
    state_nxt = state_r;  cursor_nxt = cursor_r;  scan_nxt = scan_r;
    count_nxt = count_r;  guard_nxt = guard_r;    head_nxt = head_r;
    tail_nxt = tail_r;    ready_nxt = ready_r;    clr_nxt = clr_r;
    sym_nxt = sym_r;      last_nxt = last_r;      root_nxt = root_r;
    wscan_nxt = wscan_r;  u_nxt = u_r;  fu_nxt = fu_r;  v_nxt = v_r;
    w_nxt = w_r;          f_nxt = f_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    ch_we = 1'b0;  ch_waddr = {cursor_r, sym_r};  ch_wdata = '0;
    ch_raddr = {u_r, sym_r};
    fl_we = 1'b0;  fl_waddr = v_r;  fl_wdata = '0;  fl_raddr = w_r;
    en_we = 1'b0;  en_waddr = v_r;  en_wdata = 1'b1;  en_raddr = ch_rdata;
    q_we  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_word_nxt = '{node_id: node8(scan_r), hit: 1'b0, status: STAT_OK};
          unique case (in_word.req_type)
            REQ_ADD: begin
              sym_nxt   = sym_in;
              last_nxt  = in_word.pattern_end;
              ch_raddr  = {cursor_r, sym_in};
              state_nxt = S_ADD_CHK;
            end
            REQ_FINAL: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              u_nxt     = '0;
              root_nxt  = 1'b1;
              sym_nxt   = '0;
              state_nxt = S_BF_RD;
            end
            REQ_SCAN: begin
              if (!ready_r) begin
                out_word_nxt.status = STAT_NOT_READY;
                out_valid_nxt       = 1'b1;
              end else begin
                sym_nxt   = sym_in;
                ch_raddr  = {scan_r, sym_in};
                w_nxt     = scan_r;
                guard_nxt = '0;
                wscan_nxt = 1'b1;
                state_nxt = S_WK_CHK;
              end
            end
            REQ_RESTART: begin
              scan_nxt             = '0;
              out_word_nxt.node_id = '0;
              out_valid_nxt        = 1'b1;
            end
            REQ_CLEAR: begin
              count_nxt            = (NW+1)'(1);
              cursor_nxt           = '0;
              scan_nxt             = '0;
              ready_nxt            = 1'b0;
              clr_nxt              = '0;
              out_word_nxt.node_id = '0;
              out_valid_nxt        = 1'b1;
              state_nxt            = S_CLR;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_CLR: begin
        ch_we     = 1'b1;
        ch_waddr  = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_ADD_CHK: begin
        ready_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{node_id: node8(ch_rdata), hit: 1'b0, status: STAT_OK};
        state_nxt     = S_IDLE;
        if (ch_rdata == '0) begin
          if (count_r >= MAXN) begin
            out_word_nxt = '{node_id: node8(cursor_r), hit: 1'b0, status: STAT_FULL};
            if (last_r) begin
              cursor_nxt = '0;
            end
          end else begin
            // new node takes the next number; its end mark is written fresh
            ch_we                = 1'b1;
            ch_wdata             = count_r[NW-1:0];
            en_we                = 1'b1;
            en_waddr             = count_r[NW-1:0];
            en_wdata             = last_r;
            count_nxt            = count_r + 1'b1;
            out_word_nxt.node_id = node8(count_r[NW-1:0]);
            cursor_nxt           = last_r ? '0 : count_r[NW-1:0];
          end
        end else begin
          en_we      = last_r;
          en_waddr   = ch_rdata;
          cursor_nxt = last_r ? '0 : ch_rdata;
        end
      end

      S_WK_CHK: begin
        if (ch_rdata != '0 || w_r == '0 || guard_r == MAXN) begin
          en_raddr = ch_rdata;
          if (wscan_r) begin
            scan_nxt  = ch_rdata;
            state_nxt = S_SC_OUT;
          end else begin
            fl_we     = 1'b1;
            fl_wdata  = ch_rdata;
            q_we      = 1'b1;
            tail_nxt  = tail_r + 1'b1;
            f_nxt     = ch_rdata;
            state_nxt = S_BF_E;
          end
        end else begin
          fl_raddr  = w_r;
          state_nxt = S_WK_FL;
        end
      end

      S_WK_FL: begin
        w_nxt     = fl_rdata;
        guard_nxt = guard_r + 1'b1;
        ch_raddr  = {fl_rdata, sym_r};
        state_nxt = S_WK_CHK;
      end

      S_SC_OUT: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{node_id: node8(scan_r), hit: (scan_r != '0) & en_rdata,
                          status: STAT_OK};
        state_nxt     = S_IDLE;
      end

      S_BF_RD: begin
        ch_raddr  = {u_r, sym_r};
        state_nxt = S_BF_V;
      end

      S_BF_V, S_BF_E: begin
        if (state_r == S_BF_V) begin
          if (ch_rdata != '0 && tail_r < MAXN) begin
            v_nxt = ch_rdata;
            if (root_r) begin
              fl_we    = 1'b1;
              fl_waddr = ch_rdata;
              q_we     = 1'b1;
              tail_nxt = tail_r + 1'b1;
              f_nxt    = '0;
            end else begin
              w_nxt     = fu_r;
              guard_nxt = '0;
              wscan_nxt = 1'b0;
              ch_raddr  = {fu_r, sym_r};
            end
          end
        end else begin
          // fold the end mark of the failure target
          en_we = (f_r != '0) && en_rdata;
        end
        if (state_r == S_BF_V && ch_rdata != '0 && tail_r < MAXN) begin
          // a root child goes through the fold state so the queue read trails its write
          state_nxt = root_r ? S_BF_E : S_WK_CHK;
        end else if (sym_r != '1) begin
          sym_nxt   = sym_r + 1'b1;
          state_nxt = S_BF_RD;
        end else if (head_r < tail_nxt) begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_BF_U;
        end else begin
          ready_nxt     = 1'b1;
          scan_nxt      = '0;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{node_id: 8'd0, hit: 1'b0, status: STAT_OK};
          state_nxt     = S_IDLE;
        end
      end

      S_BF_U: begin
        u_nxt     = q_rdata;
        fl_raddr  = q_rdata;
        state_nxt = S_BF_FU;
      end

      S_BF_FU: begin
        fu_nxt    = fl_rdata;
        root_nxt  = 1'b0;
        sym_nxt   = '0;
        state_nxt = S_BF_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      count_r     <= (NW+1)'(1);
      cursor_r    <= '0;
      scan_r      <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      guard_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      scan_r      <= scan_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      guard_r     <= guard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    sym_r      <= sym_nxt;
    last_r     <= last_nxt;
    root_r     <= root_nxt;
    wscan_r    <= wscan_nxt;
    u_r        <= u_nxt;
    fu_r       <= fu_nxt;
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    f_r        <= f_nxt;
  end

endmodule
